// ===== design/bclp_pkg.sv =====
// Package for the Bezier link flattener: word types, sizes and shared helpers.
// Depends on nothing; every module of the block imports it.
package bclp_pkg;

  // Curve sampling and result limits.
  localparam int CURVE_SAMPLES = 30;
  localparam int MAX_RESULTS   = 32;
  localparam int MIN_TANGENT   = 64;

  // Coordinate widths: ports are 16 bits, internal points need 18 bits signed.
  localparam int CW    = 16;
  localparam int XW    = 18;
  localparam int EXT_W = 12;
  localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(128);

  // Interpolation weight in unsigned Q1.16, 0 .. 65536.
  localparam int QF    = 16;
  localparam int QW    = QF + 1;
  localparam int Q_ONE = 1 << QF;

  // Weight of sample i is floor(i * Q_ONE / DENOM), built up step by step.
  localparam int DENOM  = (CURVE_SAMPLES > 1) ? CURVE_SAMPLES - 1 : 1;
  localparam int Q_STEP = Q_ONE / DENOM;
  localparam int Q_FRAC = Q_ONE % DENOM;
  localparam int REM_W  = $clog2(DENOM + 1) + 1;

  // Vertices per link, with and without the straight stubs.
  localparam int NS_EXT     = (CURVE_SAMPLES < MAX_RESULTS - 2) ? CURVE_SAMPLES
                                                                : MAX_RESULTS - 2;
  localparam int NP_EXT     = NS_EXT + 2;
  localparam int NP_PLAIN   = (CURVE_SAMPLES < MAX_RESULTS) ? CURVE_SAMPLES : MAX_RESULTS;
  localparam int IDX_W      = $clog2(MAX_RESULTS);
  localparam logic [IDX_W-1:0] LAST_EXT   = IDX_W'(NP_EXT - 1);
  localparam logic [IDX_W-1:0] LAST_PLAIN = IDX_W'(NP_PLAIN - 1);

  // Queue between the front and the back.
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int CFG_IW = CFG_AW - 2;
  localparam logic [CFG_IW-1:0] REG_LINK_EXTENSION = CFG_IW'(0);

  // One input word.
  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic                 last_point;
  } out_item_t;

  // A classified link, handed from the front to the back.
  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [XW-1:0] cx0;
    logic signed [XW-1:0] cx1;
    logic signed [XW-1:0] cx2;
    logic signed [XW-1:0] cx3;
    logic                 has_stubs;
  } desc_t;

  // Clamp an internal coordinate to the 16-bit port range.
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [XW-1:0] v);
    logic fits;
    fits = (v[XW-1:CW-1] == {(XW-CW+1){v[CW-1]}});
    if (fits) begin
      sat_coord = v[CW-1:0];
    end else if (v[XW-1]) begin
      sat_coord = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

endpackage

// ===== design/bclp_fifo.sv =====
// Short descriptor queue between the front and the back of the link flattener.
// Depends on bclp_pkg for the descriptor type and the depth.
module bclp_fifo import bclp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  desc_t wr_data,
  output logic  fq_full,
  input  logic  rd_en,
  output desc_t rd_data,
  output logic  fq_empty
);

  desc_t              slot_r [FQ_DEPTH];
  logic [FQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FQ_AW:0]     count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (FQ_AW+1)'(wr_en) - (FQ_AW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data  = slot_r[rd_ptr_r];
  assign fq_empty = (count_r == '0);
  assign fq_full  = (count_r == (FQ_AW+1)'(FQ_DEPTH));

endmodule

// ===== design/bclp_front.sv =====
// Front of the link flattener: accepts a word, applies the stubs and derives
// the control points. Depends on bclp_pkg for the word and descriptor types.
module bclp_front import bclp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [EXT_W-1:0] link_extension,
  input  logic             push,
  output logic             full,
  input  in_item_t         in_item,
  output logic             fq_push,
  input  logic             fq_full,
  output desc_t            fq_data
);

  logic                 st_v_r, st_v_nxt;
  in_item_t             st_item_r;
  logic signed [XW-1:0] st_x0_r, st_x3_r, st_d_r;
  logic                 st_stubs_r;

  logic                 accept;
  logic signed [XW-1:0] ext_s, x0_c, x3_c, d_c;
  logic        [XW-1:0] mag, half, tangent;

  // Hand-over: the stage frees up whenever the queue takes its descriptor.
  assign fq_push = st_v_r && !fq_full;
  assign full    = st_v_r && fq_full;
  assign accept  = push && !full;

  always_comb begin
    priority if (accept) begin
      st_v_nxt = 1'b1;
    end else if (fq_push) begin
      st_v_nxt = 1'b0;
    end else begin
      st_v_nxt = st_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
    end else begin
      st_v_r <= st_v_nxt;
    end
  end

  // Shifted curve ends and their x distance, (sx - ex) + 2 * ext.
  always_comb begin
    ext_s = signed'(XW'(link_extension));
    x0_c  = XW'(in_item.start_x) + ext_s;
    x3_c  = XW'(in_item.end_x) - ext_s;
    d_c   = XW'(in_item.start_x) - XW'(in_item.end_x) + (ext_s <<< 1);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_item_r  <= in_item;
      st_x0_r    <= x0_c;
      st_x3_r    <= x3_c;
      st_d_r     <= d_c;
      st_stubs_r <= (link_extension != '0);
    end
  end

  // Tangent is half the absolute distance, never below the minimum.
  always_comb begin
    mag     = st_d_r[XW-1] ? XW'(-st_d_r) : XW'(st_d_r);
    half    = mag >> 1;
    tangent = (half < XW'(MIN_TANGENT)) ? XW'(MIN_TANGENT) : half;
    fq_data.start_x   = st_item_r.start_x;
    fq_data.start_y   = st_item_r.start_y;
    fq_data.end_x     = st_item_r.end_x;
    fq_data.end_y     = st_item_r.end_y;
    fq_data.cx0       = st_x0_r;
    fq_data.cx1       = st_x0_r + signed'(tangent);
    fq_data.cx2       = st_x3_r - signed'(tangent);
    fq_data.cx3       = st_x3_r;
    fq_data.has_stubs = st_stubs_r;
  end

endmodule

// ===== design/bclp_lerp.sv =====
// One pipelined linear interpolation a + floor((b - a) * q / 2^16), three stages.
// Depends on bclp_pkg for the coordinate and weight widths.
module bclp_lerp import bclp_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] a,
  input  logic signed [XW-1:0] b,
  input  logic        [QW-1:0] q,
  output logic signed [XW-1:0] y
);

  localparam int PW = XW + QW + 2;
  localparam int SW = PW - QF;

  logic signed [XW:0]   d_r;
  logic signed [XW-1:0] a1_r, a2_r, y_r;
  logic        [QW-1:0] q1_r;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [SW-1:0] sum;

  // Difference, then product, then the floored step added back.
  assign prod_nxt = d_r * $signed({1'b0, q1_r});
  assign sum      = SW'(a2_r) + $signed(prod_r[PW-1:QF]);

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= (XW+1)'(b) - (XW+1)'(a);
      a1_r   <= a;
      q1_r   <= q;
      prod_r <= prod_nxt;
      a2_r   <= a1_r;
      y_r    <= XW'(sum);
    end
  end

  assign y = y_r;

endmodule

// ===== design/bclp_back.sv =====
// Back of the link flattener: walks each descriptor vertex by vertex and runs the
// de Casteljau pipeline. Depends on bclp_pkg and bclp_lerp.
module bclp_back import bclp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fq_empty,
  input  desc_t     fq_data,
  output logic      fq_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  localparam int LERP_LAT = 3;
  localparam int LAT      = 3 * LERP_LAT;
  localparam logic [REM_W-1:0] Q_FRAC_R = REM_W'(Q_FRAC);
  localparam logic [REM_W-1:0] DENOM_R  = REM_W'(DENOM);
  localparam logic [QW-1:0]    Q_STEP_R = QW'(Q_STEP);

  // Sequencer state.
  desc_t              cur_r;
  logic               cur_v_r, cur_v_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [QW-1:0]      q_r, q_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt, rsum;
  logic               wrap;

  logic adv, issue, load, is_last, is_start, is_end;

  // Pipeline and output register.
  logic [LAT-1:0]       v_r, last_r;
  logic [QW-1:0]        qd_r [2*LERP_LAT];
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic signed [XW-1:0] pt [2][4];
  logic signed [XW-1:0] l1 [2][3];
  logic signed [XW-1:0] l2 [2][2];
  logic signed [XW-1:0] l3 [2];

  // The whole pipeline moves when the output register is free or being taken.
  assign adv = !out_valid_r || pop;

  // Vertex classification for the current link.
  always_comb begin
    is_last  = (idx_r == (cur_r.has_stubs ? LAST_EXT : LAST_PLAIN));
    is_start = cur_r.has_stubs && (idx_r == '0);
    is_end   = cur_r.has_stubs && is_last;
    issue    = cur_v_r && adv;
    load     = !fq_empty && (!cur_v_r || (issue && is_last));
  end

  assign fq_pop = load;

  // Next sample weight: q += floor step, plus one when the remainder wraps.
  always_comb begin
    rsum    = rem_r + Q_FRAC_R;
    wrap    = (rsum >= DENOM_R);
    rem_nxt = wrap ? rsum - DENOM_R : rsum;
    q_nxt   = q_r + Q_STEP_R + QW'(wrap);
  end

  // Sequencer control.
  always_comb begin
    cur_v_nxt = cur_v_r;
    idx_nxt   = idx_r;
    priority if (load) begin
      cur_v_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (issue && is_last) begin
      cur_v_nxt = 1'b0;
    end else if (issue) begin
      idx_nxt   = idx_r + 1'b1;
    end else begin
      cur_v_nxt = cur_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= '0;
      q_r     <= '0;
      rem_r   <= '0;
    end else begin
      cur_v_r <= cur_v_nxt;
      idx_r   <= idx_nxt;
      if (load) begin
        q_r   <= '0;
        rem_r <= '0;
      end else if (issue && !is_start && !is_end) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= fq_data;
    end
  end

  // Stub vertices collapse all four points onto one, so any weight gives it back.
  always_comb begin
    priority if (is_start) begin
      for (int k = 0; k < 4; k++) begin
        pt[0][k] = XW'(cur_r.start_x);
        pt[1][k] = XW'(cur_r.start_y);
      end
    end else if (is_end) begin
      for (int k = 0; k < 4; k++) begin
        pt[0][k] = XW'(cur_r.end_x);
        pt[1][k] = XW'(cur_r.end_y);
      end
    end else begin
      pt[0][0] = cur_r.cx0;
      pt[0][1] = cur_r.cx1;
      pt[0][2] = cur_r.cx2;
      pt[0][3] = cur_r.cx3;
      pt[1][0] = XW'(cur_r.start_y);
      pt[1][1] = XW'(cur_r.start_y);
      pt[1][2] = XW'(cur_r.end_y);
      pt[1][3] = XW'(cur_r.end_y);
    end
  end

  // Three levels of interpolation for each axis.
  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    for (genvar j = 0; j < 3; j++) begin : g_l1
      bclp_lerp u_lerp (
        .clk (clk), .en (adv), .a (pt[ax][j]), .b (pt[ax][j+1]), .q (q_r), .y (l1[ax][j])
      );
    end
    for (genvar j = 0; j < 2; j++) begin : g_l2
      bclp_lerp u_lerp (
        .clk (clk), .en (adv), .a (l1[ax][j]), .b (l1[ax][j+1]),
        .q (qd_r[LERP_LAT-1]), .y (l2[ax][j])
      );
    end
    bclp_lerp u_l3 (
      .clk (clk), .en (adv), .a (l2[ax][0]), .b (l2[ax][1]),
      .q (qd_r[2*LERP_LAT-1]), .y (l3[ax])
    );
  end

  // Weight delay line that follows the vertices through the levels.
  always_ff @(posedge clk) begin
    if (adv) begin
      qd_r[0] <= q_r;
      for (int k = 1; k < 2 * LERP_LAT; k++) begin
        qd_r[k] <= qd_r[k-1];
      end
    end
  end

  // Valid and last-vertex flags alongside the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r <= {last_r[LAT-2:0], is_last};
    end
  end

  // Output register: one word waits here until it is popped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.point_x    <= sat_coord(l3[0]);
      out_item_r.point_y    <= sat_coord(l3[1]);
      out_item_r.last_point <= last_r[LAT-1];
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_item_r;

endmodule

// ===== design/bezier_link_curve_points.sv =====
// Flattens a horizontal-tangent cubic Bezier link into a polyline, one vertex
// per word on the result queue. A link with stubs enabled gives 32 words (start
// point, 30 curve samples, end point), with stubs off 30; the last one carries
// last_point. The back sequencer issues one vertex per clock while a link is
// loaded and results are popped without pause, and that sequencer sets the
// sustained rate. A pushed word passes the front stage, the queue, the sequencer
// register, the nine-stage interpolation pipeline and the output register.
// The front takes the next link while the back is still emitting, with a
// four-deep queue between them. Write link_extension only while idle.
module bezier_link_curve_points import bclp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  in_item_t          in_item,
  output logic              empty,
  input  logic              pop,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [EXT_W-1:0] link_ext_r;
  logic             cfg_wr;
  logic [CFG_IW-1:0] reg_idx;

  logic  fq_push, fq_full, fq_pop, fq_empty;
  desc_t fq_wdata, fq_rdata;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_LINK_EXTENSION);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_ext_r <= EXT_RESET;
    end else if (cfg_wr) begin
      link_ext_r <= pwdata[EXT_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_LINK_EXTENSION) ? CFG_DW'(link_ext_r) : '0;

  // Front, queue and back.
  bclp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .link_extension (link_ext_r),
    .push           (push),
    .full           (full),
    .in_item        (in_item),
    .fq_push        (fq_push),
    .fq_full        (fq_full),
    .fq_data        (fq_wdata)
  );

  bclp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fq_push),
    .wr_data  (fq_wdata),
    .fq_full  (fq_full),
    .rd_en    (fq_pop),
    .rd_data  (fq_rdata),
    .fq_empty (fq_empty)
  );

  bclp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .fq_empty (fq_empty),
    .fq_data  (fq_rdata),
    .fq_pop   (fq_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

// ===== design/bclp_checker.sv =====
// Port-level checks for the link flattener, bound to the top level.
// Depends on bclp_pkg for the word types and the port widths.
module bclp_checker import bclp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input out_item_t         out_item,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [CFG_AW-1:0] paddr,
  input logic [CFG_DW-1:0] pwdata,
  input logic [CFG_DW-1:0] prdata,
  input logic              pready
);

  // A waiting result word is neither lost nor changed until it is popped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result word changed or vanished before pop");

  // Reset leaves the result side empty and the input side open.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queue not empty or input blocked after reset");

  // A written extension reads back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr[CFG_AW-1:2] == REG_LINK_EXTENSION)
    |=> (paddr[CFG_AW-1:2] != REG_LINK_EXTENSION ||
         prdata[EXT_W-1:0] == $past(pwdata[EXT_W-1:0])))
    else $error("link_extension did not read back as written");

  // Only the extension bits of the register are ever non-zero.
  a_cfg_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    prdata[CFG_DW-1:EXT_W] == '0)
    else $error("unused register bits read non-zero");

endmodule

bind bezier_link_curve_points bclp_checker u_bclp_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the Bezier link flattener: random and corner-case links,
// several stub lengths, random idling on both queues and a long result hold-off.
// Depends on bclp_pkg and bezier_link_curve_points from the design folder.
module tb_top;
  import bclp_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam logic [CFG_IW-1:0] REG_UNUSED  = CFG_IW'(1);
  localparam logic [CFG_AW-1:0] ADDR_EXT    = {REG_LINK_EXTENSION, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_UNUSED = {REG_UNUSED, 2'b00};

  // Predicts the polyline of each accepted link and checks the vertices in order.
  class polyline_scoreboard;
    out_item_t   vertices_due[$];
    out_item_t   link_pts[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned pending();
      return vertices_due.size();
    endfunction

    function logic signed [CW-1:0] clamp_coord(longint v);
      if (v > 32767) begin
        return 16'sh7fff;
      end else if (v < -32768) begin
        return 16'sh8000;
      end
      return v[CW-1:0];
    endfunction

    // One interpolation step; the arithmetic shift floors towards minus infinity.
    function longint lerp_q(longint a, longint b, longint q);
      return a + (((b - a) * q) >>> QF);
    endfunction

    function longint casteljau(longint p0, longint p1, longint p2, longint p3, longint q);
      longint a01, a12, a23;
      a01 = lerp_q(p0, p1, q);
      a12 = lerp_q(p1, p2, q);
      a23 = lerp_q(p2, p3, q);
      return lerp_q(lerp_q(a01, a12, q), lerp_q(a12, a23, q), q);
    endfunction

    function void add_vertex(longint x, longint y);
      out_item_t v;
      if (link_pts.size() >= MAX_RESULTS) begin
        return;
      end
      v.point_x    = clamp_coord(x);
      v.point_y    = clamp_coord(y);
      v.last_point = 1'b0;
      link_pts.push_back(v);
    endfunction

    // Samples the curve between two (possibly out-of-range) ends.
    function void flatten_curve(longint x0, longint y0, longint x3, longint y3);
      longint x_span, tangent, q;
      x_span = (x0 > x3) ? x0 - x3 : x3 - x0;
      tangent = x_span / 2;
      if (tangent < MIN_TANGENT) begin
        tangent = MIN_TANGENT;
      end
      for (int i = 0; i < CURVE_SAMPLES; i++) begin
        q = (longint'(i) * Q_ONE) / DENOM;
        add_vertex(casteljau(x0, x0 + tangent, x3 - tangent, x3, q),
                   casteljau(y0, y0, y3, y3, q));
      end
    endfunction

    function void note_link(in_item_t w, logic [EXT_W-1:0] ext);
      longint sx, sy, ex, ey, e;
      sx = longint'(w.start_x);
      sy = longint'(w.start_y);
      ex = longint'(w.end_x);
      ey = longint'(w.end_y);
      e  = longint'({1'b0, ext});
      link_pts.delete();
      if (e != 0) begin
        add_vertex(sx, sy);
        flatten_curve(sx + e, sy, ex - e, ey);
        // The end point always survives, replacing the last sample if need be.
        if (link_pts.size() >= MAX_RESULTS) begin
          void'(link_pts.pop_back());
        end
        add_vertex(ex, ey);
      end else begin
        flatten_curve(sx, sy, ex, ey);
      end
      if (link_pts.size() != 0) begin
        link_pts[link_pts.size() - 1].last_point = 1'b1;
      end
      foreach (link_pts[k]) begin
        vertices_due.push_back(link_pts[k]);
      end
    endfunction

    function void check_vertex(out_item_t got);
      out_item_t want;
      if (vertices_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word x=%0d y=%0d last=%0b", $time,
                 got.point_x, got.point_y, got.last_point);
        return;
      end
      want = vertices_due.pop_front();
      if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.last_point !== want.last_point) begin
        errors++;
        $display("%0t: vertex mismatch, expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                 $time, want.point_x, want.point_y, want.last_point,
                 got.point_x, got.point_y, got.last_point);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n   = 1'b0;
  logic              push    = 1'b0;
  logic              full;
  in_item_t          in_item = '0;
  logic              empty;
  logic              pop     = 1'b0;
  out_item_t         out_item;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  polyline_scoreboard sb = new();
  logic [EXT_W-1:0]   cur_ext = EXT_RESET;
  int unsigned        cfg_errors = 0;
  bit                 hold_req = 1'b0;
  bit                 rx_steady = 1'b0;

  bezier_link_curve_points dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle stretch length: mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 92) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t link_of(int sx, int sy, int ex, int ey);
    in_item_t w;
    w.start_x = 16'(sx);
    w.start_y = 16'(sy);
    w.end_x   = 16'(ex);
    w.end_y   = 16'(ey);
    return w;
  endfunction

  function automatic int clamp_int(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return -32767;
      2: return 32766;
      3: return 32767;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Mixes fully random links with layouts typical of a node editor, short links and near-range ends.
  function automatic in_item_t random_link();
    int unsigned kind;
    int sx, sy;
    kind = $urandom_range(0, 99);
    sx = int'($urandom_range(0, 16000)) - 8000;
    sy = int'($urandom_range(0, 16000)) - 8000;
    if (kind < 30) begin
      return link_of($urandom, $urandom, $urandom, $urandom);
    end else if (kind < 65) begin
      return link_of(sx, sy, clamp_int(sx + int'($urandom_range(0, 8000)) - 2000),
                     clamp_int(sy + int'($urandom_range(0, 6000)) - 3000));
    end else if (kind < 80) begin
      return link_of(sx, sy, sx + int'($urandom_range(0, 320)) - 160,
                     sy + int'($urandom_range(0, 400)) - 200);
    end
    return link_of(edge_coord(), edge_coord(), edge_coord(), edge_coord());
  endfunction

  // Offers one link after an idle gap and waits until the block takes the word.
  task automatic send_link(input in_item_t w, input int unsigned gap);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (full !== 1'b0);
    sb.note_link(w, cur_ext);
  endtask

  task automatic run_random(input int unsigned count, input bit no_gaps);
    int unsigned gap;
    for (int unsigned k = 0; k < count; k++) begin
      gap = (no_gaps || $urandom_range(0, 99) < 55) ? 0 : idle_len();
      send_link(random_link(), gap);
    end
  endtask

  // One register access: setup cycle, then access until pready.
  task automatic cfg_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_extension();
    logic [CFG_DW-1:0] rd;
    cfg_access(1'b0, ADDR_EXT, '0, rd);
    if (rd !== CFG_DW'(cur_ext)) begin
      cfg_errors++;
      $display("%0t: link_extension read back, expected %0d, got %0d", $time, cur_ext, rd);
    end
  endtask

  // Lets every expected word arrive and the pipeline settle before a register write.
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_extension(input logic [EXT_W-1:0] value);
    logic [CFG_DW-1:0] rd;
    wait_idle();
    cfg_access(1'b1, ADDR_EXT, CFG_DW'(value), rd);
    cur_ext = value;
    check_extension();
  endtask

  // Result side: random pops, a long hold-off on request, and steady stretches.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && empty === 1'b0) begin
        sb.check_vertex(out_item);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (rx_steady || $urandom_range(0, 99) < 70) begin
        pop <= 1'b1;
      end else begin
        pop <= 1'b0;
        stall_left = idle_len() - 1;
      end
    end
  end

  // Ends the run when no word moves on either queue for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    in_item_t          corner_links[$];
    logic [CFG_DW-1:0] rd;

    // Zero length, full-range diagonals, stubs pushed out of range, odd distances,
    // distances around the minimum tangent, backward and vertical links.
    corner_links.push_back(link_of(0, 0, 0, 0));
    corner_links.push_back(link_of(-32768, -32768, 32767, 32767));
    corner_links.push_back(link_of(32767, 32767, -32768, -32768));
    corner_links.push_back(link_of(32767, 0, 32767, 0));
    corner_links.push_back(link_of(-32768, 100, -32768, -100));
    corner_links.push_back(link_of(0, 0, 1001, 50));
    corner_links.push_back(link_of(0, 0, -1001, -50));
    corner_links.push_back(link_of(100, 10, 150, 20));
    corner_links.push_back(link_of(0, 0, 128, 7));
    corner_links.push_back(link_of(0, 0, 129, -7));
    corner_links.push_back(link_of(0, 0, 130, 0));
    corner_links.push_back(link_of(160, 320, 1600, -800));
    corner_links.push_back(link_of(-5000, 3000, 5000, -3000));
    corner_links.push_back(link_of(4000, 0, -4000, 0));
    corner_links.push_back(link_of(0, -32768, 0, 32767));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Default stub length straight after reset.
    check_extension();
    foreach (corner_links[k]) begin
      send_link(corner_links[k], ($urandom_range(0, 1) != 0) ? idle_len() : 0);
    end

    // Stubs off.
    set_extension('0);
    for (int k = 0; k < 6; k++) begin
      send_link(corner_links[k], 0);
    end
    run_random(65, 1'b0);

    // Longest stubs, with the result side held off so that the input backs up.
    set_extension({EXT_W{1'b1}});
    hold_req = 1'b1;
    run_random(75, 1'b0);

    // Shortest stubs, both sides without idling.
    set_extension(EXT_W'(1));
    rx_steady = 1'b1;
    run_random(65, 1'b1);
    rx_steady = 1'b0;

    // A write to an unused index must leave the register alone.
    wait_idle();
    cfg_access(1'b1, ADDR_UNUSED, $urandom, rd);
    check_extension();

    for (int p = 0; p < 3; p++) begin
      set_extension(EXT_W'($urandom_range(1, 4095)));
      rx_steady = (p == 1);
      run_random(55, 1'b0);
    end
    rx_steady = 1'b0;

    wait_idle();
    if (sb.errors == 0 && cfg_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
